@@ rtl/cwis_pkg.sv @@
// Shared types and constants for the cumulative weight index search unit.
// No dependencies; imported by every module of the block.
package cwis_pkg;

   localparam int DEF_MAX_ENTRIES = 4096;
   localparam int DEF_WEIGHT_BITS = 32;

   localparam int CMD_W    = 2;
   localparam int WEIGHT_W = 32;
   localparam int VALUE_W  = 48;
   localparam int INDEX_W  = 12;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] total;
      status_type         status;
   } result_type;

   function automatic result_type make_result(input logic [INDEX_W-1:0] idx,
                                              input logic [VALUE_W-1:0] tot,
                                              input status_type st);
      result_type r;
      r.index  = idx;
      r.total  = tot;
      r.status = st;
      return r;
   endfunction

endpackage

@@ rtl/cwis_mem.sv @@
// End-total store: one write port, two read ports, registered read data.
// Depends on cwis_pkg for the data width.
module cwis_mem
   import cwis_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr_a,
   input  logic [AW-1:0]      rd_addr_b,
   output logic [VALUE_W-1:0] rd_data_a,
   output logic [VALUE_W-1:0] rd_data_b
);

   logic [VALUE_W-1:0] entries_ff [MAX_ENTRIES];
   logic [VALUE_W-1:0] rd_data_a_ff;
   logic [VALUE_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= entries_ff[rd_addr_a];
      rd_data_b_ff <= entries_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ rtl/cwis_seq.sv @@
// Command sequencer: table count and running total, append path and the
// binary search over the end-total store. Depends on cwis_pkg.
module cwis_seq
   import cwis_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic [VALUE_W-1:0]  req_query_value,
   output logic                res_valid,
   input  logic                res_take,
   output result_type          res_data,
   output logic                mem_wr_en,
   output logic [AW-1:0]       mem_wr_addr,
   output logic [VALUE_W-1:0]  mem_wr_data,
   output logic [AW-1:0]       mem_rd_addr_a,
   output logic [AW-1:0]       mem_rd_addr_b,
   input  logic [VALUE_W-1:0]  mem_rd_data_a,
   input  logic [VALUE_W-1:0]  mem_rd_data_b
);

   localparam logic [WEIGHT_W-1:0] WMASK = (WEIGHT_BITS >= WEIGHT_W) ? '1 :
      WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [VALUE_W-1:0] total_ff, total_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hix_ff, hix_in;        // exclusive upper bound
   logic [AW-1:0]      mid_ff, mid_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   result_type         res_ff, res_in;

   logic [VALUE_W:0]   sum_full;
   logic [VALUE_W-1:0] sum_sat;
   logic [CW-1:0]      count_m1;
   logic [AW-1:0]      mid0;
   logic [CW-1:0]      mid_ext;
   logic [CW-1:0]      mid_up;
   logic [CW:0]        sum_l;
   logic [CW:0]        sum_g;
   logic [AW-1:0]      nmid_l;
   logic [AW-1:0]      nmid_g;
   logic [VALUE_W-1:0] begin_val;
   logic               less;
   logic               greater;
   logic [AW-1:0]      rd_addr;

   assign sum_full = {1'b0, total_ff} + (VALUE_W + 1)'(req_weight & WMASK);
   assign sum_sat  = sum_full[VALUE_W] ? '1 : sum_full[VALUE_W-1:0];

   // first probe sits at the middle of the whole table
   assign count_m1 = count_ff - CW'(1);
   assign mid0     = AW'(count_m1 >> 1);

   // both possible next probes are ready before the compare settles
   assign mid_ext = CW'(mid_ff);
   assign mid_up  = mid_ext + CW'(1);
   assign sum_l   = {1'b0, lo_ff} + {1'b0, mid_ext} - (CW + 1)'(1);
   assign sum_g   = {1'b0, mid_ext} + {1'b0, hix_ff};
   assign nmid_l  = AW'(sum_l >> 1);
   assign nmid_g  = AW'(sum_g >> 1);

   assign begin_val = (mid_ff == '0) ? '0 : mem_rd_data_b;
   assign less      = value_ff < begin_val;
   assign greater   = value_ff > mem_rd_data_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hix_ff   <= hix_in;
      mid_ff   <= mid_in;
      value_ff <= value_in;
      res_ff   <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      lo_in     = lo_ff;
      hix_in    = hix_ff;
      mid_in    = mid_ff;
      value_in  = value_ff;
      res_in    = res_ff;
      mem_wr_en = 1'b0;
      rd_addr   = (count_ff == '0) ? '0 : mid0;
      req_stall = (state_ff != S_IDLE);
      res_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (command_type'(req_command))
                  CMD_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                     res_in   = make_result('0, '0, ST_OK);
                     state_in = S_RESP;
                  end
                  CMD_APPEND: begin
                     if (count_ff == CW'(MAX_ENTRIES)) begin
                        res_in = make_result('0, total_ff, ST_FULL);
                     end else begin
                        mem_wr_en = 1'b1;
                        total_in  = sum_sat;
                        count_in  = count_ff + CW'(1);
                        res_in    = make_result(INDEX_W'(count_ff), sum_sat, ST_OK);
                     end
                     state_in = S_RESP;
                  end
                  CMD_QUERY: begin
                     value_in = req_query_value;
                     if (count_ff == '0 || req_query_value > total_ff) begin
                        res_in   = make_result('0, total_ff, ST_NOT_FOUND);
                        state_in = S_RESP;
                     end else begin
                        // the read of mid0 is already under way this cycle
                        lo_in    = '0;
                        hix_in   = count_ff;
                        mid_in   = mid0;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     res_in   = make_result('0, total_ff, ST_OK);
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (less) begin
               hix_in = mid_ext;
               if (lo_ff < mid_ext) begin
                  mid_in  = nmid_l;
                  rd_addr = nmid_l;
               end else begin
                  res_in   = make_result('0, total_ff, ST_NOT_FOUND);
                  state_in = S_RESP;
               end
            end else if (greater) begin
               lo_in = mid_up;
               if (mid_up < hix_ff) begin
                  mid_in  = nmid_g;
                  rd_addr = nmid_g;
               end else begin
                  res_in   = make_result('0, total_ff, ST_NOT_FOUND);
                  state_in = S_RESP;
               end
            end else begin
               res_in   = make_result(INDEX_W'(mid_ff), total_ff, ST_OK);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign mem_wr_addr   = count_ff[AW-1:0];
   assign mem_wr_data   = sum_sat;
   assign mem_rd_addr_a = rd_addr;
   assign mem_rd_addr_b = (rd_addr == '0) ? '0 : rd_addr - AW'(1);
   assign res_data      = res_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond table depth");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (mid_ext >= lo_ff && mid_ext < hix_ff))
      else $error("search probe outside live range");

   a_range_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && state_in == S_SEARCH)
      |=> ((hix_ff - lo_ff) < $past(hix_ff - lo_ff)))
      else $error("search range failed to shrink");

   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> !mem_wr_en)
      else $error("store written during a search");

endmodule

@@ rtl/cumulative_weight_index_search_unit.sv @@
// Cumulative weight index search unit. Keeps a table of running weight totals
// (unsigned, 16 fraction bits, saturating at 48 bits) in one synchronous
// memory and answers clear, append and query beats. A query binary-searches
// the table with one memory probe per cycle, making at most ceil(log2(entries + 1))
// probes before it answers. Clear, append and the unused command answer without
// a search. The probe loop through the memory's registered read sets the pace
// of a query. Results sit in an output register, so a new beat is taken while
// the last result is still stalled. No clearing pass: the table is never
// searched beyond the entries written since the last clear.
module cumulative_weight_index_search_unit
   import cwis_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic [VALUE_W-1:0]  req_query_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [INDEX_W-1:0]  rsp_index,
   output logic [VALUE_W-1:0]  rsp_total,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic               res_valid;
   logic               res_take;
   result_type         res_data;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [VALUE_W-1:0] mem_wr_data;
   logic [AW-1:0]      mem_rd_addr_a;
   logic [AW-1:0]      mem_rd_addr_b;
   logic [VALUE_W-1:0] mem_rd_data_a;
   logic [VALUE_W-1:0] mem_rd_data_b;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_res_ff, rsp_res_in;

   cwis_seq #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_weight      (req_weight),
      .req_query_value (req_query_value),
      .res_valid       (res_valid),
      .res_take        (res_take),
      .res_data        (res_data),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_addr_a   (mem_rd_addr_a),
      .mem_rd_addr_b   (mem_rd_addr_b),
      .mem_rd_data_a   (mem_rd_data_a),
      .mem_rd_data_b   (mem_rd_data_b)
   );

   cwis_mem #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

   // output register takes a result when empty or draining this cycle
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_index  = rsp_res_ff.index;
   assign rsp_total  = rsp_res_ff.total;
   assign rsp_status = rsp_res_ff.status;

endmodule

@@ test/cumulative_weight_index_search_unit_test.sv @@
// Testbench for the cumulative weight index search unit: clear, append and query beats
// checked against a behavioural model of the running-total table kept in a scoreboard.
// Depends on cwis_pkg and the cumulative_weight_index_search_unit RTL.
`timescale 1ns / 100ps

module cumulative_weight_index_search_unit_test;
   import cwis_pkg::*;

   localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_BEATS = 1600;

   // Behavioural copy of the table; one expected result per accepted beat.
   class weight_table_scoreboard;
      logic [VALUE_W-1:0] end_totals [TABLE_DEPTH];
      int unsigned        entry_count;
      logic [VALUE_W-1:0] running_total;
      result_type         expected_q [$];
      int unsigned        fails;

      function new();
         entry_count   = 0;
         running_total = '0;
         fails         = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [WEIGHT_W-1:0] w,
                                 logic [VALUE_W-1:0] v);
         logic [VALUE_W:0]   sum;
         logic [VALUE_W-1:0] low_bound;
         int                 lo;
         int                 hi;
         int                 mid;
         result_type         r;
         r.index  = '0;
         r.total  = running_total;
         r.status = ST_OK;
         case (cmd)
            CMD_CLEAR: begin
               entry_count   = 0;
               running_total = '0;
               r.total       = '0;
            end
            CMD_APPEND: begin
               if (entry_count >= TABLE_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  sum = {1'b0, running_total} + w;
                  running_total = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];
                  end_totals[entry_count] = running_total;
                  r.index = entry_count[INDEX_W-1:0];
                  r.total = running_total;
                  entry_count++;
               end
            end
            CMD_QUERY: begin
               r.status = ST_NOT_FOUND;
               if (entry_count != 0 && v <= running_total) begin
                  lo = 0;
                  hi = entry_count - 1;
                  // first probed interval that holds the value wins
                  while (lo <= hi) begin
                     mid = (lo + hi) / 2;
                     low_bound = (mid == 0) ? '0 : end_totals[mid-1];
                     if (v < low_bound) begin
                        hi = mid - 1;
                     end else if (v > end_totals[mid]) begin
                        lo = mid + 1;
                     end else begin
                        r.index  = mid[INDEX_W-1:0];
                        r.status = ST_OK;
                        break;
                     end
                  end
               end
            end
            default: ;
         endcase
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] tot,
                                 logic [STATUS_W-1:0] st);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result beat: index %0d total %0h status %0d", idx, tot, st);
            fails++;
            return;
         end
         want = expected_q.pop_front();
         if (idx !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, idx);
            fails++;
         end
         if (tot !== want.total) begin
            $error("total: expected %0h, got %0h", want.total, tot);
            fails++;
         end
         if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            fails++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_command = CMD_CLEAR;
   logic [WEIGHT_W-1:0] req_weight = '0;
   logic [VALUE_W-1:0]  req_query_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_index;
   logic [VALUE_W-1:0]  rsp_total;
   logic [STATUS_W-1:0] rsp_status;

   logic                calm = 1'b0;
   int unsigned         beats_sent = 0;

   weight_table_scoreboard sb = new();

   cumulative_weight_index_search_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_weight      (req_weight),
      .req_query_value (req_query_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_index       (rsp_index),
      .rsp_total       (rsp_total),
      .rsp_status      (rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 7);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_index, rsp_total, rsp_status);
      end
   end

   function automatic logic [VALUE_W-1:0] rand_value();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[VALUE_W-1:0];
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      logic [WEIGHT_W-1:0] w;
      case ($urandom_range(19))
         0, 1, 2:                w = '0;
         3, 4, 5, 6, 7, 8, 9:    w = $urandom_range(32'h1FFFF);
         19:                     w = '1;
         default:                w = $urandom();
      endcase
      return w;
   endfunction

   // Aims mostly at interval bounds, where ties and off-by-one slips live.
   function automatic logic [VALUE_W-1:0] pick_query();
      logic [VALUE_W-1:0] tot;
      logic [63:0]        wide;
      int unsigned        k;
      tot = sb.running_total;
      if (sb.entry_count == 0) begin
         return ($urandom_range(1) == 0) ? rand_value() : '0;
      end
      k = $urandom_range(sb.entry_count - 1);
      case ($urandom_range(8))
         0, 1:    wide = {16'd0, sb.end_totals[k]};
         2:       wide = (k == 0) ? 64'd0 : {16'd0, sb.end_totals[k-1]};
         3, 4:    wide = {16'd0, rand_value()} % ({16'd0, tot} + 64'd1);
         5:       wide = (tot == '1) ? {16'd0, tot} : {16'd0, tot} + 64'd1;
         6:       wide = {16'd0, rand_value()};
         7:       wide = {16'd0, sb.end_totals[k]} + 64'd1;
         default: wide = 64'd0;
      endcase
      return wide[VALUE_W-1:0];
   endfunction

   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [WEIGHT_W-1:0] w,
                            input logic [VALUE_W-1:0] v);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_weight      <= w;
      req_query_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(cmd, w, v);
      beats_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int unsigned random_start;
      int unsigned random_goal;
      int unsigned fill_start;
      int unsigned drain_cycles;
      int          n_app;
      int          n_q;
      int          i;
      bit          fill_done;

      fill_done = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, zero-width intervals, extremes, unused command
      send_beat(CMD_QUERY, '0, '0);
      send_beat(CMD_QUERY, '1, '1);
      send_beat(CMD_APPEND, '0, '0);
      send_beat(CMD_APPEND, '1, '1);
      send_beat(CMD_APPEND, 32'd1, '0);
      send_beat(CMD_APPEND, '0, '0);
      send_beat(CMD_QUERY, '0, 48'd0);
      send_beat(CMD_QUERY, '0, 48'hFFFF_FFFF);
      send_beat(CMD_QUERY, '0, 48'h1_0000_0000);
      send_beat(CMD_QUERY, '0, 48'h1_0000_0001);
      send_beat(CMD_QUERY, '0, '1);
      send_beat(CMD_UNUSED, '1, '1);
      send_beat(CMD_CLEAR, '1, '1);
      send_beat(CMD_QUERY, '0, 48'd0);
      send_beat(CMD_APPEND, 32'h8000_0000, '0);
      send_beat(CMD_QUERY, '0, 48'h8000_0000);
      send_beat(CMD_QUERY, '0, 48'h7FFF_FFFF);
      send_beat(CMD_UNUSED, '0, '0);
      send_beat(CMD_CLEAR, '0, '0);
      wait_drained();

      random_start = beats_sent;
      random_goal  = beats_sent + RANDOM_BEATS;
      while (beats_sent < random_goal) begin
         calm = (beats_sent - random_start >= 400) && (beats_sent - random_start < 700);
         if (!fill_done && beats_sent - random_start >= 800) begin
            // one run up to a full table, past it, then queries over all of it
            wait_drained();
            fill_start = beats_sent;
            send_beat(CMD_CLEAR, $urandom(), rand_value());
            for (i = 0; i < TABLE_DEPTH + 3; i++) begin
               send_beat(CMD_APPEND, pick_weight(), rand_value());
            end
            for (i = 0; i < 40; i++) begin
               send_beat(CMD_QUERY, $urandom(), pick_query());
            end
            send_beat(CMD_CLEAR, $urandom(), rand_value());
            random_goal += beats_sent - fill_start;
            fill_done = 1'b1;
         end
         if ($urandom_range(9) == 0) begin
            n_q = $urandom_range(1, 6);
            for (i = 0; i < n_q; i++) begin
               send_beat(CMD_W'($urandom_range(3)), $urandom(), rand_value());
            end
         end else begin
            if ($urandom_range(3) != 0) send_beat(CMD_CLEAR, $urandom(), rand_value());
            n_app = $urandom_range(1, 40);
            for (i = 0; i < n_app; i++) begin
               send_beat(CMD_APPEND, pick_weight(), rand_value());
            end
            n_q = $urandom_range(4, 30);
            for (i = 0; i < n_q; i++) begin
               if ($urandom_range(9) == 0) begin
                  send_beat(CMD_APPEND, pick_weight(), rand_value());
               end else begin
                  send_beat(CMD_QUERY, $urandom(), pick_query());
               end
            end
         end
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      drain_cycles = 0;
      while (sb.pending() != 0 && drain_cycles < 50000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (40) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.fails++;
      end
      if (sb.fails == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
